@@ rtl/core/esl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esl_pkg: shared definitions for the emergency stop latch
// Register map, reset values, and the transaction and status records.
// ----------------------------------------------------------------------------
package esl_pkg;

   localparam int unsigned CsrAddrWidth  = 5;
   localparam int unsigned CsrDataWidth  = 32;
   localparam int unsigned RegIndexWidth = 3;

   localparam logic [RegIndexWidth-1:0] RegStopDebounce  = 3'd0;
   localparam logic [RegIndexWidth-1:0] RegLiftPeriod    = 3'd1;
   localparam logic [RegIndexWidth-1:0] RegTiltPeriod    = 3'd2;
   localparam logic [RegIndexWidth-1:0] RegCommandWindow = 3'd3;
   localparam logic [RegIndexWidth-1:0] RegConfirmations = 3'd4;

   localparam logic [15:0] StopDebounceReset  = 16'd20;
   localparam logic [15:0] LiftPeriodReset    = 16'd100;
   localparam logic [15:0] TiltPeriodReset    = 16'd2500;
   localparam logic [15:0] CommandWindowReset = 16'd1000;
   localparam logic [3:0]  ConfirmationsReset = 4'd3;

   localparam logic ReqSample  = 1'b0;
   localparam logic ReqCommand = 1'b1;

   typedef struct packed {
      logic [15:0] debounce_ms;
      logic [15:0] lift_hold_ms;
      logic [15:0] tilt_hold_ms;
      logic [15:0] cmd_window_ms;
      logic [3:0]  confirmations_needed;
   } cfg_type;

   typedef struct packed {
      logic        req_type;
      logic [31:0] now_ms;
      logic [1:0]  lift_pins_n;
      logic [1:0]  stop_pins_n;
      logic        latch_request;
   } item_type;

   typedef struct packed {
      logic       latched;
      logic       stop_qualified;
      logic       lift_qualified;
      logic       tilt_qualified;
      logic       soft_requested;
      logic       release_refused;
      logic [1:0] wheels_lifted;
   } status_type;

endpackage

@@ rtl/core/esl_csr.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esl_csr: configuration registers
// APB-style register file holding the timing periods and confirmation count.
// ----------------------------------------------------------------------------
module esl_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [esl_pkg::CsrAddrWidth-1:0]  csr_paddr,
   input  logic [esl_pkg::CsrDataWidth-1:0]  csr_pwdata,
   output logic [esl_pkg::CsrDataWidth-1:0]  csr_prdata,
   output logic                              csr_pready,
   output esl_pkg::cfg_type                  cfg
);

   esl_pkg::cfg_type                   cfg_ff;
   esl_pkg::cfg_type                   cfg_in;
   logic [esl_pkg::RegIndexWidth-1:0]  reg_index;
   logic                               write_en;

   assign csr_pready = 1'b1;
   assign reg_index  = csr_paddr[esl_pkg::CsrAddrWidth-1:2];
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (reg_index)
            esl_pkg::RegStopDebounce:  cfg_in.debounce_ms          = csr_pwdata[15:0];
            esl_pkg::RegLiftPeriod:    cfg_in.lift_hold_ms         = csr_pwdata[15:0];
            esl_pkg::RegTiltPeriod:    cfg_in.tilt_hold_ms         = csr_pwdata[15:0];
            esl_pkg::RegCommandWindow: cfg_in.cmd_window_ms        = csr_pwdata[15:0];
            esl_pkg::RegConfirmations: cfg_in.confirmations_needed = csr_pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         esl_pkg::RegStopDebounce:  csr_prdata = {16'd0, cfg_ff.debounce_ms};
         esl_pkg::RegLiftPeriod:    csr_prdata = {16'd0, cfg_ff.lift_hold_ms};
         esl_pkg::RegTiltPeriod:    csr_prdata = {16'd0, cfg_ff.tilt_hold_ms};
         esl_pkg::RegCommandWindow: csr_prdata = {16'd0, cfg_ff.cmd_window_ms};
         esl_pkg::RegConfirmations: csr_prdata = {28'd0, cfg_ff.confirmations_needed};
         default:                   csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms          <= esl_pkg::StopDebounceReset;
         cfg_ff.lift_hold_ms         <= esl_pkg::LiftPeriodReset;
         cfg_ff.tilt_hold_ms         <= esl_pkg::TiltPeriodReset;
         cfg_ff.cmd_window_ms        <= esl_pkg::CommandWindowReset;
         cfg_ff.confirmations_needed <= esl_pkg::ConfirmationsReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/core/esl_timer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esl_timer: condition qualification timer
// Tracks when a condition started and reports once it has held for a period.
// ----------------------------------------------------------------------------
module esl_timer (
   input  logic        clock,
   input  logic        reset,
   input  logic        update,
   input  logic        cond,
   input  logic [31:0] now_ms,
   input  logic [15:0] period_ms,
   output logic        qualified
);

   logic        running_ff;
   logic        running_in;
   logic [31:0] start_ff;
   logic [31:0] start_in;
   logic [31:0] elapsed;

   // wrapping difference, modulo 2^32
   assign elapsed   = now_ms - start_ff;
   assign qualified = cond && running_ff && (elapsed >= {16'd0, period_ms});

   always_comb begin
      running_in = running_ff;
      start_in   = start_ff;
      if (update) begin
         running_in = cond;
         // first sample with the condition only arms the timer
         if (cond && !running_ff) begin
            start_in = now_ms;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
      end else begin
         running_ff <= running_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
   end

endmodule

@@ rtl/core/esl_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esl_core: latch state and per-transaction update
// Applies one sample or command to the latch state and yields the new status.
// ----------------------------------------------------------------------------
module esl_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  esl_pkg::item_type    item,
   input  esl_pkg::cfg_type     cfg,
   output esl_pkg::status_type  status_next
);

   esl_pkg::status_type status_ff;
   logic                cmd_pending_ff;
   logic                cmd_pending_in;
   logic                cmd_kind_ff;
   logic                cmd_kind_in;
   logic [3:0]          cmd_count_ff;
   logic [3:0]          cmd_count_in;
   logic [31:0]         cmd_start_ff;
   logic [31:0]         cmd_start_in;

   logic [1:0]  wheels;
   logic        raw_lift;
   logic        raw_stop;
   logic        both_lifted;
   logic        is_cmd;
   logic [31:0] cmd_age;
   logic        restart;
   logic [3:0]  count_inc;
   logic        confirmed;
   logic        do_sample;
   logic        timer_update;
   logic        stop_q;
   logic        lift_q;
   logic        tilt_q;
   logic        latch_after;

   assign wheels      = {1'b0, ~item.lift_pins_n[0]} + {1'b0, ~item.lift_pins_n[1]};
   assign raw_lift    = ~&item.lift_pins_n;
   assign raw_stop    = ~&item.stop_pins_n;
   assign both_lifted = ~|item.lift_pins_n;
   assign is_cmd      = (item.req_type == esl_pkg::ReqCommand);

   assign cmd_age   = item.now_ms - cmd_start_ff;
   assign restart   = !cmd_pending_ff || (cmd_kind_ff != item.latch_request) ||
                      (cmd_age > {16'd0, cfg.cmd_window_ms});
   assign count_inc = cmd_count_ff + 4'd1;
   assign confirmed = is_cmd && !restart && (count_inc >= cfg.confirmations_needed);

   // a confirmed release resamples the pins like a sample transaction
   assign do_sample    = !is_cmd || (confirmed && !item.latch_request);
   assign timer_update = advance && do_sample;

   esl_timer u_stop_timer (
      .clock     (clock),
      .reset     (reset),
      .update    (timer_update),
      .cond      (raw_stop),
      .now_ms    (item.now_ms),
      .period_ms (cfg.debounce_ms),
      .qualified (stop_q)
   );

   esl_timer u_lift_timer (
      .clock     (clock),
      .reset     (reset),
      .update    (timer_update),
      .cond      (both_lifted),
      .now_ms    (item.now_ms),
      .period_ms (cfg.lift_hold_ms),
      .qualified (lift_q)
   );

   esl_timer u_tilt_timer (
      .clock     (clock),
      .reset     (reset),
      .update    (timer_update),
      .cond      (raw_lift),
      .now_ms    (item.now_ms),
      .period_ms (cfg.tilt_hold_ms),
      .qualified (tilt_q)
   );

   assign latch_after = status_ff.latched || stop_q || lift_q || tilt_q;

   always_comb begin
      status_next = status_ff;
      if (do_sample) begin
         status_next.wheels_lifted   = wheels;
         status_next.stop_qualified  = stop_q;
         status_next.lift_qualified  = lift_q;
         status_next.tilt_qualified  = tilt_q;
         status_next.latched         = latch_after;
         status_next.release_refused = latch_after && (raw_stop || raw_lift);
      end
      if (confirmed) begin
         if (item.latch_request) begin
            status_next.soft_requested = 1'b1;
            status_next.latched        = 1'b1;
         end else if (raw_stop || raw_lift) begin
            status_next.release_refused = 1'b1;
         end else begin
            status_next.latched         = 1'b0;
            status_next.soft_requested  = 1'b0;
            status_next.release_refused = 1'b0;
         end
      end
   end

   always_comb begin
      cmd_pending_in = cmd_pending_ff;
      cmd_kind_in    = cmd_kind_ff;
      cmd_count_in   = cmd_count_ff;
      cmd_start_in   = cmd_start_ff;
      if (is_cmd) begin
         if (restart) begin
            cmd_pending_in = 1'b1;
            cmd_kind_in    = item.latch_request;
            cmd_count_in   = 4'd1;
            cmd_start_in   = item.now_ms;
         end else if (confirmed) begin
            cmd_pending_in = 1'b0;
            cmd_count_in   = 4'd0;
         end else begin
            cmd_count_in   = count_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff      <= '0;
         cmd_pending_ff <= 1'b0;
         cmd_kind_ff    <= 1'b0;
         cmd_count_ff   <= 4'd0;
         cmd_start_ff   <= 32'd0;
      end else if (advance) begin
         status_ff      <= status_next;
         cmd_pending_ff <= cmd_pending_in;
         cmd_kind_ff    <= cmd_kind_in;
         cmd_count_ff   <= cmd_count_in;
         cmd_start_ff   <= cmd_start_in;
      end
   end

endmodule

@@ rtl/core/emergency_stop_latch.sv @@
`timescale 1ns / 1ps
// A transaction accepted into the input register has its status loaded into rsp_* once
// the output register is free; one transaction per cycle while the status is not stalled.
// A new transaction is taken while a status waits on rsp_ready only if the input is empty.
// Reset (synchronous, active high) clears the latch, flags, timers, command
// sequence and both valid bits, and loads the default register values.
// ----------------------------------------------------------------------------
// emergency_stop_latch: timed emergency stop and tilt latch
// Qualifies stop, lift and tilt pins over time and confirms software commands.
// ----------------------------------------------------------------------------
module emergency_stop_latch (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_type,
   input  logic [31:0]                       req_now_ms,
   input  logic [1:0]                        req_lift_pins_n,
   input  logic [1:0]                        req_stop_pins_n,
   input  logic                              req_latch_request,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_latched,
   output logic                              rsp_stop_qualified,
   output logic                              rsp_lift_qualified,
   output logic                              rsp_tilt_qualified,
   output logic                              rsp_soft_requested,
   output logic                              rsp_release_refused,
   output logic [1:0]                        rsp_wheels_lifted,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [esl_pkg::CsrAddrWidth-1:0]  csr_paddr,
   input  logic [esl_pkg::CsrDataWidth-1:0]  csr_pwdata,
   output logic [esl_pkg::CsrDataWidth-1:0]  csr_prdata,
   output logic                              csr_pready
);

   esl_pkg::cfg_type    cfg;
   esl_pkg::item_type   item_ff;
   logic                in_valid_ff;
   esl_pkg::status_type status_next;
   esl_pkg::status_type rsp_ff;
   logic                rsp_valid_ff;
   logic                advance;

   // move the held transaction into the output register when it is free
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   esl_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   esl_core u_core (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .item        (item_ff),
      .cfg         (cfg),
      .status_next (status_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff.req_type      <= req_type;
         item_ff.now_ms        <= req_now_ms;
         item_ff.lift_pins_n   <= req_lift_pins_n;
         item_ff.stop_pins_n   <= req_stop_pins_n;
         item_ff.latch_request <= req_latch_request;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= status_next;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_latched         = rsp_ff.latched;
   assign rsp_stop_qualified  = rsp_ff.stop_qualified;
   assign rsp_lift_qualified  = rsp_ff.lift_qualified;
   assign rsp_tilt_qualified  = rsp_ff.tilt_qualified;
   assign rsp_soft_requested  = rsp_ff.soft_requested;
   assign rsp_release_refused = rsp_ff.release_refused;
   assign rsp_wheels_lifted   = rsp_ff.wheels_lifted;

endmodule

@@ rtl/core/esl_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esl_checker: port-level checks for the emergency stop latch
// Watches the status channel for consistency across reset and stalls.
// ----------------------------------------------------------------------------
module esl_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic                              rsp_latched,
   input logic                              rsp_stop_qualified,
   input logic                              rsp_lift_qualified,
   input logic                              rsp_tilt_qualified,
   input logic                              rsp_soft_requested,
   input logic                              rsp_release_refused,
   input logic [1:0]                        rsp_wheels_lifted
);

   // no status may appear in the cycle after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("status valid right after reset");

   // hold a stalled status transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_latched) &&
         $stable(rsp_soft_requested) && $stable(rsp_release_refused) &&
         $stable(rsp_wheels_lifted))
      else $error("stalled status changed");

   a_soft_latched: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_soft_requested |-> rsp_latched)
      else $error("soft request without latch");

   a_qual_latched: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_stop_qualified || rsp_lift_qualified || rsp_tilt_qualified)
         |-> rsp_latched)
      else $error("qualified condition without latch");

   a_lift_wheels: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_lift_qualified |-> rsp_wheels_lifted == 2'd2)
      else $error("lift qualified without both wheels lifted");

endmodule

bind emergency_stop_latch esl_checker u_esl_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_latched         (rsp_latched),
   .rsp_stop_qualified  (rsp_stop_qualified),
   .rsp_lift_qualified  (rsp_lift_qualified),
   .rsp_tilt_qualified  (rsp_tilt_qualified),
   .rsp_soft_requested  (rsp_soft_requested),
   .rsp_release_refused (rsp_release_refused),
   .rsp_wheels_lifted   (rsp_wheels_lifted)
);

@@ bench/tb_emergency_stop_latch.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_emergency_stop_latch: self-checking bench for the emergency stop latch
// A queue-fed driver sends pin samples and software commands with random gaps.
// A monitor stalls the status channel at random and checks every status
// against an in-bench model of the timers, the latch and the command
// confirmation logic. Register settings change between traffic phases
// through the APB port and are read back.
// ----------------------------------------------------------------------------
module tb_emergency_stop_latch;

   localparam int unsigned StallLimit = 1000;
   localparam logic [1:0]  PinsIdle   = 2'b11;

   typedef enum int {TimerStop = 0, TimerLift = 1, TimerTilt = 2} timer_index_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_type = esl_pkg::ReqSample;
   logic [31:0] req_now_ms = '0;
   logic [1:0]  req_lift_pins_n = PinsIdle;
   logic [1:0]  req_stop_pins_n = PinsIdle;
   logic        req_latch_request = 1'b0;

   logic        rsp_valid;
   logic        rsp_ready = 1'b1;
   logic        rsp_latched;
   logic        rsp_stop_qualified;
   logic        rsp_lift_qualified;
   logic        rsp_tilt_qualified;
   logic        rsp_soft_requested;
   logic        rsp_release_refused;
   logic [1:0]  rsp_wheels_lifted;

   logic                              csr_psel = 1'b0;
   logic                              csr_penable = 1'b0;
   logic                              csr_pwrite = 1'b0;
   logic [esl_pkg::CsrAddrWidth-1:0]  csr_paddr = '0;
   logic [esl_pkg::CsrDataWidth-1:0]  csr_pwdata = '0;
   logic [esl_pkg::CsrDataWidth-1:0]  csr_prdata;
   logic                              csr_pready;

   esl_pkg::item_type   pending_items [$];
   esl_pkg::status_type pending_status [$];

   int unsigned mismatch_count = 0;
   int unsigned quiet_cycles = 0;
   int          req_gap_left = 0;
   int          rsp_stall_left = 0;
   bit          req_idle_on = 1'b1;
   bit          rsp_idle_on = 1'b1;
   logic [31:0] stim_now = '0;

   // model of the block: configuration, flags, timers and command sequence
   esl_pkg::cfg_type model_cfg = '{esl_pkg::StopDebounceReset, esl_pkg::LiftPeriodReset,
                                   esl_pkg::TiltPeriodReset, esl_pkg::CommandWindowReset,
                                   esl_pkg::ConfirmationsReset};
   bit          model_latch, model_stop, model_lift, model_tilt;
   bit          model_soft, model_refused;
   bit [1:0]    model_wheels;
   bit          raw_stop, raw_lift;
   bit          timer_on [3];
   bit [31:0]   timer_t0 [3];
   bit          cmd_open, cmd_latch_kind;
   bit [3:0]    cmd_tally;
   bit [31:0]   cmd_t0;

   emergency_stop_latch u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_type            (req_type),
      .req_now_ms          (req_now_ms),
      .req_lift_pins_n     (req_lift_pins_n),
      .req_stop_pins_n     (req_stop_pins_n),
      .req_latch_request   (req_latch_request),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_latched         (rsp_latched),
      .rsp_stop_qualified  (rsp_stop_qualified),
      .rsp_lift_qualified  (rsp_lift_qualified),
      .rsp_tilt_qualified  (rsp_tilt_qualified),
      .rsp_soft_requested  (rsp_soft_requested),
      .rsp_release_refused (rsp_release_refused),
      .rsp_wheels_lifted   (rsp_wheels_lifted),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .csr_pready          (csr_pready)
   );

   always #10 clock = ~clock;

   task automatic report_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   function automatic int idle_draw(input bit enabled);
      return enabled ? $urandom_range(0, 11) : 0;
   endfunction

   // first sample of a held condition only arms its timer
   function automatic bit timed_hold(input timer_index_type which, input bit cond,
                                     input logic [15:0] period, input logic [31:0] now);
      if (!cond) begin
         timer_on[which] = 1'b0;
         timer_t0[which] = '0;
         return 1'b0;
      end
      if (!timer_on[which]) begin
         timer_on[which] = 1'b1;
         timer_t0[which] = now;
         return 1'b0;
      end
      return (now - timer_t0[which]) >= {16'd0, period};
   endfunction

   function automatic void pin_sample(input logic [31:0] now, input logic [1:0] lift_n,
                                      input logic [1:0] stop_n);
      model_wheels = {1'b0, ~lift_n[0]} + {1'b0, ~lift_n[1]};
      raw_lift = model_wheels != 2'd0;
      raw_stop = stop_n != PinsIdle;
      model_stop = timed_hold(TimerStop, raw_stop, model_cfg.debounce_ms, now);
      model_lift = timed_hold(TimerLift, model_wheels == 2'd2, model_cfg.lift_hold_ms, now);
      model_tilt = timed_hold(TimerTilt, raw_lift, model_cfg.tilt_hold_ms, now);
      if (model_stop || model_lift || model_tilt)
         model_latch = 1'b1;
      model_refused = model_latch && (raw_stop || raw_lift);
   endfunction

   function automatic void soft_command(input logic [31:0] now, input logic want_latch,
                                        input logic [1:0] lift_n, input logic [1:0] stop_n);
      if (!cmd_open || cmd_latch_kind != want_latch ||
          (now - cmd_t0) > {16'd0, model_cfg.cmd_window_ms}) begin
         cmd_open = 1'b1;
         cmd_latch_kind = want_latch;
         cmd_tally = 4'd1;
         cmd_t0 = now;
         return;
      end
      cmd_tally = cmd_tally + 4'd1;
      if (cmd_tally < model_cfg.confirmations_needed)
         return;
      cmd_open = 1'b0;
      cmd_tally = 4'd0;
      if (want_latch) begin
         model_soft = 1'b1;
         model_latch = 1'b1;
         return;
      end
      // release resamples the pins and is refused while anything is raw
      pin_sample(now, lift_n, stop_n);
      if (raw_stop || raw_lift) begin
         model_refused = 1'b1;
         return;
      end
      model_latch = 1'b0;
      model_soft = 1'b0;
      model_refused = 1'b0;
   endfunction

   function automatic esl_pkg::status_type next_latch_status(input esl_pkg::item_type it);
      esl_pkg::status_type st;
      if (it.req_type == esl_pkg::ReqCommand)
         soft_command(it.now_ms, it.latch_request, it.lift_pins_n, it.stop_pins_n);
      else
         pin_sample(it.now_ms, it.lift_pins_n, it.stop_pins_n);
      st.latched         = model_latch;
      st.stop_qualified  = model_stop;
      st.lift_qualified  = model_lift;
      st.tilt_qualified  = model_tilt;
      st.soft_requested  = model_soft;
      st.release_refused = model_refused;
      st.wheels_lifted   = model_wheels;
      return st;
   endfunction

   // input channel: hold until accepted, then idle or advance
   always @(posedge clock) begin : req_driver
      esl_pkg::item_type taken;
      esl_pkg::item_type next_item;
      if (reset) begin
         req_valid <= 1'b0;
         req_gap_left <= 0;
      end else begin
         if (req_valid && req_ready) begin
            taken = '{req_type, req_now_ms, req_lift_pins_n, req_stop_pins_n,
                      req_latch_request};
            pending_status.push_back(next_latch_status(taken));
         end
         if (!req_valid || req_ready) begin
            if (req_gap_left != 0) begin
               req_valid <= 1'b0;
               req_gap_left <= req_gap_left - 1;
            end else if (pending_items.size() != 0) begin
               next_item = pending_items.pop_front();
               req_type <= next_item.req_type;
               req_now_ms <= next_item.now_ms;
               req_lift_pins_n <= next_item.lift_pins_n;
               req_stop_pins_n <= next_item.stop_pins_n;
               req_latch_request <= next_item.latch_request;
               req_valid <= 1'b1;
               req_gap_left <= idle_draw(req_idle_on);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : rsp_backpressure
      int stall;
      if (!reset) begin
         if (rsp_ready) begin
            if (rsp_valid) begin
               stall = idle_draw(rsp_idle_on);
               if (stall != 0) begin
                  rsp_ready <= 1'b0;
                  rsp_stall_left <= stall;
               end
            end
         end else if (rsp_stall_left <= 1) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_stall_left <= rsp_stall_left - 1;
         end
      end
   end

   always @(posedge clock) begin : status_monitor
      esl_pkg::status_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_status.size() == 0) begin
            report_mismatch("status transaction with nothing outstanding");
         end else begin
            want = pending_status.pop_front();
            if (rsp_latched !== want.latched)
               report_mismatch($sformatf("latched got %b want %b", rsp_latched, want.latched));
            if (rsp_stop_qualified !== want.stop_qualified)
               report_mismatch($sformatf("stop_qualified got %b want %b",
                                         rsp_stop_qualified, want.stop_qualified));
            if (rsp_lift_qualified !== want.lift_qualified)
               report_mismatch($sformatf("lift_qualified got %b want %b",
                                         rsp_lift_qualified, want.lift_qualified));
            if (rsp_tilt_qualified !== want.tilt_qualified)
               report_mismatch($sformatf("tilt_qualified got %b want %b",
                                         rsp_tilt_qualified, want.tilt_qualified));
            if (rsp_soft_requested !== want.soft_requested)
               report_mismatch($sformatf("soft_requested got %b want %b",
                                         rsp_soft_requested, want.soft_requested));
            if (rsp_release_refused !== want.release_refused)
               report_mismatch($sformatf("release_refused got %b want %b",
                                         rsp_release_refused, want.release_refused));
            if (rsp_wheels_lifted !== want.wheels_lifted)
               report_mismatch($sformatf("wheels_lifted got %0d want %0d",
                                         rsp_wheels_lifted, want.wheels_lifted));
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
         $display("tb_emergency_stop_latch: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic push_item(input logic kind, input logic [31:0] now, input logic [1:0] lift_n,
                            input logic [1:0] stop_n, input logic want_latch);
      esl_pkg::item_type it;
      it.req_type = kind;
      it.now_ms = now;
      it.lift_pins_n = lift_n;
      it.stop_pins_n = stop_n;
      it.latch_request = want_latch;
      pending_items.push_back(it);
   endtask

   // write one register, then read it back
   task automatic csr_write(input logic [esl_pkg::RegIndexWidth-1:0] index,
                            input logic [31:0] value);
      logic [31:0] readback;
      logic [31:0] want_rd;
      bit          mapped;
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      readback = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      mapped = 1'b1;
      want_rd = {16'd0, value[15:0]};
      case (index)
         esl_pkg::RegStopDebounce:  model_cfg.debounce_ms = value[15:0];
         esl_pkg::RegLiftPeriod:    model_cfg.lift_hold_ms = value[15:0];
         esl_pkg::RegTiltPeriod:    model_cfg.tilt_hold_ms = value[15:0];
         esl_pkg::RegCommandWindow: model_cfg.cmd_window_ms = value[15:0];
         esl_pkg::RegConfirmations: begin
            model_cfg.confirmations_needed = value[3:0];
            want_rd = {28'd0, value[3:0]};
         end
         default: mapped = 1'b0;
      endcase
      if (mapped && readback !== want_rd)
         report_mismatch($sformatf("register %0d read 0x%08h want 0x%08h",
                                   index, readback, want_rd));
   endtask

   // junk in the upper bits checks the width masking
   task automatic apply_settings(input logic [15:0] debounce, input logic [15:0] lift,
                                 input logic [15:0] tilt, input logic [15:0] window,
                                 input logic [3:0] confirmations);
      logic [31:0] v;
      v = $urandom(); v[15:0] = debounce;
      csr_write(esl_pkg::RegStopDebounce, v);
      v = $urandom(); v[15:0] = lift;
      csr_write(esl_pkg::RegLiftPeriod, v);
      v = $urandom(); v[15:0] = tilt;
      csr_write(esl_pkg::RegTiltPeriod, v);
      v = $urandom(); v[15:0] = window;
      csr_write(esl_pkg::RegCommandWindow, v);
      v = $urandom(); v[3:0] = confirmations;
      csr_write(esl_pkg::RegConfirmations, v);
   endtask

   // mostly held pin patterns and repeated commands, some noise
   task automatic queue_random_traffic(input int count, input int step_max);
      int   made;
      int   run_len;
      int   pick;
      logic [1:0] lift_n;
      logic [1:0] stop_n;
      logic want;
      made = 0;
      while (made < count) begin
         pick = $urandom_range(0, 9);
         if (pick <= 5) begin
            lift_n = $urandom_range(0, 1) ? PinsIdle : 2'($urandom_range(0, 3));
            stop_n = $urandom_range(0, 1) ? PinsIdle : 2'($urandom_range(0, 3));
            run_len = $urandom_range(1, 8);
            for (int i = 0; i < run_len; i++) begin
               stim_now = stim_now + $urandom_range(0, step_max);
               push_item(esl_pkg::ReqSample, stim_now, lift_n, stop_n,
                         1'($urandom_range(0, 1)));
               made++;
            end
         end else if (pick <= 8) begin
            want = 1'($urandom_range(0, 1));
            lift_n = ($urandom_range(0, 3) != 0) ? PinsIdle : 2'($urandom_range(0, 3));
            stop_n = ($urandom_range(0, 3) != 0) ? PinsIdle : 2'($urandom_range(0, 3));
            run_len = $urandom_range(1, model_cfg.confirmations_needed + 1);
            for (int i = 0; i < run_len; i++) begin
               stim_now = stim_now + $urandom_range(0, step_max);
               push_item(esl_pkg::ReqCommand, stim_now, lift_n, stop_n, want);
               made++;
            end
         end else begin
            stim_now = $urandom();
            push_item(1'($urandom_range(0, 1)), stim_now, 2'($urandom_range(0, 3)),
                      2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
            made++;
         end
      end
   endtask

   // look after the edge has settled so a just-popped item counts as in flight
   task automatic drain_status();
      while (pending_items.size() != 0 || req_valid || pending_status.size() != 0)
         @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // default settings: stop debounce, lift, tilt, refused and confirmed commands
      push_item(esl_pkg::ReqSample,  32'd0,    PinsIdle, PinsIdle, 1'b1);
      push_item(esl_pkg::ReqSample,  32'd10,   PinsIdle, 2'b10,    1'b0);
      push_item(esl_pkg::ReqSample,  32'd20,   PinsIdle, 2'b10,    1'b0);
      push_item(esl_pkg::ReqSample,  32'd30,   PinsIdle, 2'b01,    1'b0);
      push_item(esl_pkg::ReqSample,  32'd40,   PinsIdle, PinsIdle, 1'b0);
      push_item(esl_pkg::ReqSample,  32'd60,   2'b00,    PinsIdle, 1'b0);
      push_item(esl_pkg::ReqSample,  32'd160,  2'b00,    PinsIdle, 1'b0);
      push_item(esl_pkg::ReqSample,  32'd170,  2'b10,    PinsIdle, 1'b0);
      push_item(esl_pkg::ReqSample,  32'd2560, 2'b01,    PinsIdle, 1'b0);
      push_item(esl_pkg::ReqCommand, 32'd2600, 2'b01,    PinsIdle, 1'b0);
      push_item(esl_pkg::ReqCommand, 32'd2610, 2'b01,    PinsIdle, 1'b0);
      push_item(esl_pkg::ReqCommand, 32'd2620, 2'b01,    PinsIdle, 1'b0);
      push_item(esl_pkg::ReqSample,  32'd2700, PinsIdle, PinsIdle, 1'b0);
      push_item(esl_pkg::ReqCommand, 32'd2710, PinsIdle, PinsIdle, 1'b0);
      push_item(esl_pkg::ReqCommand, 32'd2720, PinsIdle, PinsIdle, 1'b0);
      push_item(esl_pkg::ReqCommand, 32'd2730, PinsIdle, PinsIdle, 1'b0);
      push_item(esl_pkg::ReqCommand, 32'd2800, PinsIdle, PinsIdle, 1'b1);
      push_item(esl_pkg::ReqCommand, 32'd2810, PinsIdle, PinsIdle, 1'b1);
      push_item(esl_pkg::ReqCommand, 32'd2820, PinsIdle, PinsIdle, 1'b1);
      // kind change and window expiry restart the sequence
      push_item(esl_pkg::ReqCommand, 32'd3000, 2'b00,    2'b00,    1'b0);
      push_item(esl_pkg::ReqCommand, 32'd4001, 2'b00,    2'b00,    1'b0);
      push_item(esl_pkg::ReqCommand, 32'd4500, 2'b00,    2'b00,    1'b0);
      push_item(esl_pkg::ReqCommand, 32'd5000, PinsIdle, PinsIdle, 1'b0);
      // debounce across the time wrap
      push_item(esl_pkg::ReqSample,  32'hFFFF_FFF0, PinsIdle, 2'b10, 1'b0);
      push_item(esl_pkg::ReqSample,  32'h0000_0004, PinsIdle, 2'b10, 1'b0);
      push_item(esl_pkg::ReqSample,  32'hFFFF_FFFF, 2'b00,    2'b00, 1'b1);
      stim_now = 32'd4;
      queue_random_traffic(120, 400);
      drain_status();

      // unmapped registers must not disturb anything
      for (int idx = esl_pkg::RegConfirmations + 1; idx < (1 << esl_pkg::RegIndexWidth); idx++)
         csr_write(3'(idx), $urandom());

      // zero periods, zero window, zero confirmations
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 4'd0);
      stim_now = $urandom();
      push_item(esl_pkg::ReqSample,  stim_now, PinsIdle, 2'b10, 1'b0);
      push_item(esl_pkg::ReqSample,  stim_now, PinsIdle, 2'b10, 1'b0);
      push_item(esl_pkg::ReqCommand, stim_now, PinsIdle, PinsIdle, 1'b1);
      push_item(esl_pkg::ReqCommand, stim_now, PinsIdle, PinsIdle, 1'b1);
      push_item(esl_pkg::ReqCommand, stim_now + 32'd1, PinsIdle, PinsIdle, 1'b0);
      push_item(esl_pkg::ReqCommand, stim_now + 32'd2, PinsIdle, PinsIdle, 1'b0);
      push_item(esl_pkg::ReqCommand, stim_now + 32'd2, PinsIdle, PinsIdle, 1'b0);
      stim_now = stim_now + 32'd2;
      queue_random_traffic(80, 3);
      drain_status();

      // single confirmation, widest window
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b0;
      apply_settings(16'd1, 16'd2, 16'd5, 16'hFFFF, 4'd1);
      queue_random_traffic(80, 4);
      drain_status();

      // longest periods, most confirmations, time near the wrap
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b1;
      apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd15);
      stim_now = 32'hFFFE_0000 + $urandom_range(0, 32'h0001_0000);
      queue_random_traffic(80, 12000);
      drain_status();

      for (int p = 0; p < 4; p++) begin
         req_idle_on = 1'($urandom_range(0, 1));
         rsp_idle_on = 1'($urandom_range(0, 1));
         apply_settings(16'($urandom_range(0, 400)), 16'($urandom_range(0, 400)),
                        16'($urandom_range(0, 400)), 16'($urandom_range(0, 1500)),
                        4'($urandom_range(1, 5)));
         queue_random_traffic(85, 60);
         drain_status();
      end

      if (mismatch_count == 0)
         $display("tb_emergency_stop_latch: clean");
      else
         $display("tb_emergency_stop_latch: errors");
      $finish;
   end

endmodule
